// ----- src/assert_macros.svh -----
// assertion macros used by the checker file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, off while reset is asserted
`define RSZ_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion, also checked during reset
`define RSZ_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- src/rsz_pkg.sv -----
// types and constants of the planar image resampler
// no dependencies
package rsz_pkg;

    typedef enum logic {
        CMD_LOAD     = 1'b0,
        CMD_RESAMPLE = 1'b1
    } cmd_t;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 11;

    localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DST_WIDTH   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DST_HEIGHT  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_INTERP_MODE = 3'd4;

    localparam logic MODE_BILINEAR = 1'b0;
    localparam logic MODE_NEAREST  = 1'b1;

    localparam int PIX_W      = 8;
    localparam int SRC_SIZE_W = 8;
    localparam int DST_SIZE_W = 11;
    localparam int NUM_W      = 19;   // (2d+1)*src
    localparam int NUM_LO_W   = 9;    // numerator bits streamed through the divider
    localparam int Q_W        = 24;   // quotient bits, one per stage
    localparam int REM_W      = 11;
    localparam int FRAC_W     = 16;
    localparam int WGT_W      = 17;
    localparam int PROD_W     = 25;
    localparam int ACC_W      = 42;
    localparam int NUM_BANKS  = 4;

    typedef struct packed {
        cmd_t       command;
        logic [9:0] col;
        logic [9:0] row;
        logic [1:0] plane;
        logic [7:0] pixel_in;
    } rsz_in_t;

    typedef struct packed {
        logic [7:0] pixel_out;
        logic       status;
    } rsz_out_t;

    // transaction fields carried alongside the divider
    typedef struct packed {
        cmd_t       command;
        logic       ok;
        logic [1:0] plane;
        logic [9:0] col;
        logic [9:0] row;
        logic [7:0] pixel_in;
    } rsz_tag_t;

    // neighbourhood selection and weights handed to the interpolator
    typedef struct packed {
        logic              ok;
        logic              xpar;
        logic              ypar;
        logic              xsame;
        logic              ysame;
        logic [FRAC_W-1:0] fx;
        logic [FRAC_W-1:0] fy;
    } rsz_meta_t;

endpackage

// ----- src/image_resampler_bilinear_nearest.sv -----
// top level of the planar image resampler: config registers, input stage,
// source position, banked image store; depends on rsz_pkg, rsz_ram, rsz_div, rsz_interp
//
// One transaction is accepted every clock while the result side is not stalled.
// A resample reaches m_valid through thirty register stages: one input stage,
// a 24-stage divider that forms the source position (one quotient bit per stage),
// one store read and four arithmetic stages. A load writes the store at the same
// point where resamples read it, so order of loads and resamples is kept. The
// store is split into four banks by column and row parity so the 2x2
// neighbourhood is read together. The store has no clearing pass; pixels
// must be loaded before they are sampled.
module image_resampler_bilinear_nearest import rsz_pkg::*; #(
    parameter int MAX_WIDTH  = 128,
    parameter int MAX_HEIGHT = 128,
    parameter int PLANES     = 3
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wr_data,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  rsz_in_t               s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output rsz_out_t              m_data
);

    localparam int XW   = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
    localparam int YW   = (MAX_HEIGHT > 2) ? $clog2(MAX_HEIGHT) : 1;
    localparam int XHW  = (XW > 1) ? XW - 1 : 1;
    localparam int YHW  = (YW > 1) ? YW - 1 : 1;
    localparam int BANK_DEPTH = PLANES * (2 ** (XHW + YHW));
    localparam int BAW  = $clog2(BANK_DEPTH);

    function automatic logic [SRC_SIZE_W-1:0] clamp_idx(
        input logic signed [9:0]     v,
        input logic [SRC_SIZE_W-1:0] hi
    );
        logic [SRC_SIZE_W-1:0] r;
        if (v < 10'sd0) begin
            r = '0;
        end else if (v > $signed({2'b00, hi})) begin
            r = hi;
        end else begin
            r = v[SRC_SIZE_W-1:0];
        end
        return r;
    endfunction

    logic [SRC_SIZE_W-1:0] src_width_reg, src_height_reg;
    logic [DST_SIZE_W-1:0] dst_width_reg, dst_height_reg;
    logic                  interp_mode_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            src_width_reg   <= 8'd128;
            src_height_reg  <= 8'd128;
            dst_width_reg   <= 11'd128;
            dst_height_reg  <= 11'd128;
            interp_mode_reg <= MODE_BILINEAR;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                REG_SRC_WIDTH:   src_width_reg   <= cfg_wr_data[SRC_SIZE_W-1:0];
                REG_SRC_HEIGHT:  src_height_reg  <= cfg_wr_data[SRC_SIZE_W-1:0];
                REG_DST_WIDTH:   dst_width_reg   <= cfg_wr_data;
                REG_DST_HEIGHT:  dst_height_reg  <= cfg_wr_data;
                REG_INTERP_MODE: interp_mode_reg <= cfg_wr_data[0];
                default: ;
            endcase
        end
    end

    // effective source size
    logic [SRC_SIZE_W-1:0] sw, sh, swm1, shm1;
    logic                  nearest;

    always_comb begin
        if (src_width_reg == '0) begin
            sw = 8'd1;
        end else if (13'(src_width_reg) > 13'(MAX_WIDTH)) begin
            sw = 8'(MAX_WIDTH);
        end else begin
            sw = src_width_reg;
        end
        if (src_height_reg == '0) begin
            sh = 8'd1;
        end else if (13'(src_height_reg) > 13'(MAX_HEIGHT)) begin
            sh = 8'(MAX_HEIGHT);
        end else begin
            sh = src_height_reg;
        end
        swm1    = sw - 8'd1;
        shm1    = sh - 8'd1;
        nearest = (interp_mode_reg == MODE_NEAREST);
    end

    // handshake: whole pipeline advances unless the result is stalled
    logic en;
    assign en      = !m_valid || m_ready;
    assign s_ready = en;

    // input stage
    logic       plane_ok, load_ok, bad;
    rsz_tag_t   in_tag;
    logic [NUM_W-1:0] num_x, num_y;

    always_comb begin
        plane_ok = ({1'b0, s_data.plane} < 3'(PLANES));
        load_ok  = (s_data.col < {2'b00, sw}) && (s_data.row < {2'b00, sh}) && plane_ok;
        bad      = ({1'b0, s_data.col} >= dst_width_reg)
                || ({1'b0, s_data.row} >= dst_height_reg) || !plane_ok;
        in_tag.command  = s_data.command;
        in_tag.ok       = (s_data.command == CMD_LOAD) ? load_ok : !bad;
        in_tag.plane    = s_data.plane;
        in_tag.col      = s_data.col;
        in_tag.row      = s_data.row;
        in_tag.pixel_in = s_data.pixel_in;
        num_x = NUM_W'({s_data.col, 1'b1}) * NUM_W'(sw);
        num_y = NUM_W'({s_data.row, 1'b1}) * NUM_W'(sh);
    end

    logic             in_vld_reg;
    rsz_tag_t         in_tag_reg;
    logic [NUM_W-1:0] num_x_reg, num_y_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (en) begin
            in_vld_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            in_tag_reg <= in_tag;
            num_x_reg  <= num_x;
            num_y_reg  <= num_y;
        end
    end

    // source position
    logic           div_vld;
    rsz_tag_t       div_tag;
    logic [Q_W-1:0] q_x, q_y;

    rsz_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (in_vld_reg),
        .in_tag    (in_tag_reg),
        .in_num_x  (num_x_reg),
        .in_num_y  (num_y_reg),
        .div_x     (dst_width_reg),
        .div_y     (dst_height_reg),
        .out_valid (div_vld),
        .out_tag   (div_tag),
        .out_q_x   (q_x),
        .out_q_y   (q_y)
    );

    // neighbour indices
    logic [Q_W:0]          pos_x, pos_y;
    logic signed [9:0]     lx, ly, lx1, ly1;
    logic [SRC_SIZE_W-1:0] cx0, cx1, cy0, cy1;
    logic [XW-1:0]         cx0w;
    logic [YW-1:0]         cy0w;
    logic [XHW-1:0]        xo_h, xe_h;
    logic [YHW-1:0]        yo_h, ye_h;
    rsz_meta_t             meta;

    always_comb begin
        pos_x = {1'b0, q_x} + 25'd32768;
        pos_y = {1'b0, q_y} + 25'd32768;
        lx  = nearest ? {2'b00, q_x[Q_W-1:16]} : ({1'b0, pos_x[Q_W:16]} - 10'd1);
        ly  = nearest ? {2'b00, q_y[Q_W-1:16]} : ({1'b0, pos_y[Q_W:16]} - 10'd1);
        lx1 = lx + 10'sd1;
        ly1 = ly + 10'sd1;
        cx0 = clamp_idx(lx, swm1);
        cx1 = clamp_idx(lx1, swm1);
        cy0 = clamp_idx(ly, shm1);
        cy1 = clamp_idx(ly1, shm1);
        cx0w = XW'(cx0);
        cy0w = YW'(cy0);
        xo_h = XHW'(cx0w >> 1);
        xe_h = XHW'(({1'b0, cx0w} + 1'b1) >> 1);
        yo_h = YHW'(cy0w >> 1);
        ye_h = YHW'(({1'b0, cy0w} + 1'b1) >> 1);
        meta.ok    = div_tag.ok;
        meta.xpar  = cx0[0];
        meta.ypar  = cy0[0];
        meta.xsame = (cx0 == cx1);
        meta.ysame = (cy0 == cy1);
        meta.fx    = nearest ? '0 : pos_x[FRAC_W-1:0];
        meta.fy    = nearest ? '0 : pos_y[FRAC_W-1:0];
    end

    // banked image store, bank index {row parity, column parity}
    logic [NUM_BANKS-1:0][PIX_W-1:0] bank_q;
    logic                            is_load;
    logic [BAW-1:0]                  plane_base, waddr;

    always_comb begin
        is_load    = div_vld && (div_tag.command == CMD_LOAD) && div_tag.ok;
        plane_base = BAW'(div_tag.plane) << (XHW + YHW);
        waddr      = BAW'({YHW'(div_tag.row >> 1), XHW'(div_tag.col >> 1)}) | plane_base;
    end

    for (genvar b = 0; b < NUM_BANKS; b++) begin : g_bank
        localparam logic BX = logic'(b % 2);
        localparam logic BY = logic'(b / 2);
        logic [XHW-1:0] xa;
        logic [YHW-1:0] ya;
        logic [BAW-1:0] raddr;
        logic           we;

        assign xa    = BX ? xo_h : xe_h;
        assign ya    = BY ? yo_h : ye_h;
        assign raddr = BAW'({ya, xa}) | plane_base;
        assign we    = en && is_load && (div_tag.col[0] == BX) && (div_tag.row[0] == BY);

        rsz_ram #(
            .DATA_W (PIX_W),
            .DEPTH  (BANK_DEPTH)
        ) u_ram (
            .aclk  (aclk),
            .we    (we),
            .waddr (waddr),
            .wdata (div_tag.pixel_in),
            .re    (en),
            .raddr (raddr),
            .rdata (bank_q[b])
        );
    end

    rsz_interp u_interp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .en         (en),
        .meta_valid (div_vld && (div_tag.command == CMD_RESAMPLE)),
        .meta       (meta),
        .bank_q     (bank_q),
        .m_valid    (m_valid),
        .m_data     (m_data)
    );

endmodule

// ----- src/rsz_ram.sv -----
// generic single write, single read ram with registered read data
// no dependencies
module rsz_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [DATA_W-1:0]        wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [DATA_W-1:0]        rdata
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- src/rsz_div.sv -----
// pipelined restoring divider, one quotient bit per stage, for both axes
// depends on rsz_pkg
module rsz_div import rsz_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  en,
    input  logic                  in_valid,
    input  rsz_tag_t              in_tag,
    input  logic [NUM_W-1:0]      in_num_x,
    input  logic [NUM_W-1:0]      in_num_y,
    input  logic [DST_SIZE_W-1:0] div_x,
    input  logic [DST_SIZE_W-1:0] div_y,
    output logic                  out_valid,
    output rsz_tag_t              out_tag,
    output logic [Q_W-1:0]        out_q_x,
    output logic [Q_W-1:0]        out_q_y
);

    logic             vld_reg [Q_W];
    rsz_tag_t         tag_reg [Q_W];
    logic [REM_W-1:0] rx_reg  [Q_W];
    logic [REM_W-1:0] ry_reg  [Q_W];
    logic [Q_W-1:0]   wx_reg  [Q_W];
    logic [Q_W-1:0]   wy_reg  [Q_W];

    for (genvar k = 0; k < Q_W; k++) begin : g_stage
        logic             v_in;
        rsz_tag_t         t_in;
        logic [REM_W-1:0] rx_in, ry_in;
        logic [Q_W-1:0]   wx_in, wy_in;
        logic [REM_W:0]   tx, ty;
        logic             gx, gy;
        logic [REM_W-1:0] rx_next, ry_next;

        if (k == 0) begin : g_first
            assign v_in  = in_valid;
            assign t_in  = in_tag;
            assign rx_in = REM_W'(in_num_x[NUM_W-1:NUM_LO_W]);
            assign ry_in = REM_W'(in_num_y[NUM_W-1:NUM_LO_W]);
            assign wx_in = {in_num_x[NUM_LO_W-1:0], {(Q_W-NUM_LO_W){1'b0}}};
            assign wy_in = {in_num_y[NUM_LO_W-1:0], {(Q_W-NUM_LO_W){1'b0}}};
        end else begin : g_next
            assign v_in  = vld_reg[k-1];
            assign t_in  = tag_reg[k-1];
            assign rx_in = rx_reg[k-1];
            assign ry_in = ry_reg[k-1];
            assign wx_in = wx_reg[k-1];
            assign wy_in = wy_reg[k-1];
        end

        assign tx = {rx_in, wx_in[Q_W-1]};
        assign ty = {ry_in, wy_in[Q_W-1]};
        assign gx = (tx >= {1'b0, div_x});
        assign gy = (ty >= {1'b0, div_y});
        assign rx_next = gx ? REM_W'(tx - {1'b0, div_x}) : tx[REM_W-1:0];
        assign ry_next = gy ? REM_W'(ty - {1'b0, div_y}) : ty[REM_W-1:0];

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[k] <= 1'b0;
            end else if (en) begin
                vld_reg[k] <= v_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                tag_reg[k] <= t_in;
                rx_reg[k]  <= rx_next;
                ry_reg[k]  <= ry_next;
                wx_reg[k]  <= {wx_in[Q_W-2:0], gx};
                wy_reg[k]  <= {wy_in[Q_W-2:0], gy};
            end
        end
    end

    assign out_valid = vld_reg[Q_W-1];
    assign out_tag   = tag_reg[Q_W-1];
    assign out_q_x   = wx_reg[Q_W-1];
    assign out_q_y   = wy_reg[Q_W-1];

endmodule

// ----- src/rsz_interp.sv -----
// neighbour selection, weighted sum, rounding and result register
// depends on rsz_pkg
module rsz_interp import rsz_pkg::*; (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            en,
    input  logic                            meta_valid,
    input  rsz_meta_t                       meta,
    input  logic [NUM_BANKS-1:0][PIX_W-1:0] bank_q,
    output logic                            m_valid,
    output rsz_out_t                        m_data
);

    // read stage, aligned with the bank read data
    logic      d_vld_reg;
    rsz_meta_t d_reg;

    // products
    logic              e_vld_reg, e_ok_reg;
    logic [PROD_W-1:0] e_p_reg [4];
    logic [FRAC_W-1:0] e_fy_reg;

    // horizontal sums
    logic              f_vld_reg, f_ok_reg;
    logic [PROD_W-1:0] f_h0_reg, f_h1_reg;
    logic [FRAC_W-1:0] f_fy_reg;

    // vertical products
    logic             g_vld_reg, g_ok_reg;
    logic [ACC_W-1:0] g_m0_reg, g_m1_reg;

    logic     out_vld_reg;
    rsz_out_t out_reg;

    logic              bx1, by1;
    logic [PIX_W-1:0]  v00, v10, v01, v11;
    logic [WGT_W-1:0]  wx0, wx1, wy0, wy1;
    logic [ACC_W-1:0]  acc;
    logic [9:0]        rounded;
    rsz_out_t          out_next;

    always_comb begin
        bx1 = d_reg.xsame ? d_reg.xpar : ~d_reg.xpar;
        by1 = d_reg.ysame ? d_reg.ypar : ~d_reg.ypar;
        v00 = bank_q[{d_reg.ypar, d_reg.xpar}];
        v10 = bank_q[{d_reg.ypar, bx1}];
        v01 = bank_q[{by1, d_reg.xpar}];
        v11 = bank_q[{by1, bx1}];
        wx1 = {1'b0, d_reg.fx};
        wx0 = WGT_W'(17'h10000 - wx1);
        wy1 = {1'b0, f_fy_reg};
        wy0 = WGT_W'(17'h10000 - wy1);
    end

    always_comb begin
        acc      = g_m0_reg + g_m1_reg + ACC_W'(32'h8000_0000);
        rounded  = acc[ACC_W-1:32];
        out_next = '{pixel_out: 8'd0, status: 1'b1};
        if (g_ok_reg) begin
            out_next.status    = 1'b0;
            out_next.pixel_out = (rounded > 10'd255) ? 8'd255 : rounded[7:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            d_vld_reg   <= 1'b0;
            e_vld_reg   <= 1'b0;
            f_vld_reg   <= 1'b0;
            g_vld_reg   <= 1'b0;
            out_vld_reg <= 1'b0;
        end else if (en) begin
            d_vld_reg   <= meta_valid;
            e_vld_reg   <= d_vld_reg;
            f_vld_reg   <= e_vld_reg;
            g_vld_reg   <= f_vld_reg;
            out_vld_reg <= g_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            d_reg      <= meta;
            e_ok_reg   <= d_reg.ok;
            e_fy_reg   <= d_reg.fy;
            e_p_reg[0] <= PROD_W'(v00) * PROD_W'(wx0);
            e_p_reg[1] <= PROD_W'(v10) * PROD_W'(wx1);
            e_p_reg[2] <= PROD_W'(v01) * PROD_W'(wx0);
            e_p_reg[3] <= PROD_W'(v11) * PROD_W'(wx1);
            f_ok_reg   <= e_ok_reg;
            f_fy_reg   <= e_fy_reg;
            f_h0_reg   <= e_p_reg[0] + e_p_reg[1];
            f_h1_reg   <= e_p_reg[2] + e_p_reg[3];
            g_ok_reg   <= f_ok_reg;
            g_m0_reg   <= ACC_W'(f_h0_reg) * ACC_W'(wy0);
            g_m1_reg   <= ACC_W'(f_h1_reg) * ACC_W'(wy1);
            out_reg    <= out_next;
        end
    end

    assign m_valid = out_vld_reg;
    assign m_data  = out_reg;

endmodule

// ----- src/rsz_chk.sv -----
// port-level checker for the image resampler, bound to the top level
// depends on rsz_pkg and assert_macros.svh
`include "assert_macros.svh"

module rsz_chk import rsz_pkg::*; (
    input logic     aclk,
    input logic     aresetn,
    input logic     s_ready,
    input logic     m_valid,
    input logic     m_ready,
    input rsz_out_t m_data
);

    `RSZ_ASSERT(a_out_hold, aclk, aresetn, m_valid && !m_ready |=> m_valid && $stable(m_data), "result changed while stalled")
    `RSZ_ASSERT_ALWAYS(a_rst_clear, aclk, !aresetn |=> !m_valid, "result valid after reset")
    `RSZ_ASSERT(a_stall_in, aclk, aresetn, m_valid && !m_ready |-> !s_ready, "input taken while result stalled")
    `RSZ_ASSERT(a_free_in, aclk, aresetn, !m_valid |-> s_ready, "input refused with empty result register")
    `RSZ_ASSERT(a_bad_zero, aclk, aresetn, m_valid && m_data.status |-> m_data.pixel_out == 8'd0, "error result with nonzero pixel")

endmodule

bind image_resampler_bilinear_nearest rsz_chk u_rsz_chk (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
